// ===== hdl/sdmd_pkg.sv =====
package sdmd_pkg;

   // Parser phases, one-hot.
   typedef enum logic [9:0] {
      PH_FLAG       = 10'b00_0000_0001,
      PH_ACK_COUNT  = 10'b00_0000_0010,
      PH_ACK_ID     = 10'b00_0000_0100,
      PH_BF_COUNT   = 10'b00_0000_1000,
      PH_BF_ID      = 10'b00_0001_0000,
      PH_BF_BYTE    = 10'b00_0010_0000,
      PH_FRAG_COUNT = 10'b00_0100_0000,
      PH_FRAG_HDR   = 10'b00_1000_0000,
      PH_FRAG_DATA  = 10'b01_0000_0000,
      PH_TAIL       = 10'b10_0000_0000
   } phase_type;

   // Result kinds.
   localparam logic [2:0] KIND_ACK_ID    = 3'd0;
   localparam logic [2:0] KIND_ACK_BITS  = 3'd1;
   localparam logic [2:0] KIND_FRAG_HDR  = 3'd2;
   localparam logic [2:0] KIND_FRAG_DATA = 3'd3;
   localparam logic [2:0] KIND_DGRAM_OK  = 3'd4;
   localparam logic [2:0] KIND_ERROR     = 3'd5;

   // Error codes.
   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_ACKS_CUT  = 3'd1;
   localparam logic [2:0] ERR_BITS_CUT  = 3'd2;
   localparam logic [2:0] ERR_NO_COUNT  = 3'd3;
   localparam logic [2:0] ERR_HDR_CUT   = 3'd4;
   localparam logic [2:0] ERR_DATA_CUT  = 3'd5;

   // Byte positions within multi-byte fields.
   localparam logic [2:0] POS_ID_LAST  = 3'd3;
   localparam logic [2:0] POS_HDR_LAST = 3'd6;

   localparam logic [4:0] BF_COUNT_MAX = 5'd31;
   localparam logic [7:0] BF_INDEX_MAX = 8'd217;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_datagram;
   } item_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] message_id;
      logic [7:0]  fragment_index;
      logic [6:0]  ack_mask;
      logic        field_end;
      logic        is_last_fragment;
      logic [13:0] fragment_size;
      logic [7:0]  payload_byte;
      logic        fragment_done;
      logic [2:0]  fail_code;
      logic        datagram_done;
   } result_type;

endpackage

// ===== hdl/sdmd_req_if.sv =====
interface sdmd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_datagram;

   modport source (output valid, output data_byte, output end_of_datagram, input ready);
   modport sink (input valid, input data_byte, input end_of_datagram, output ready);
endinterface

// ===== hdl/sdmd_rsp_if.sv =====
interface sdmd_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [31:0] message_id;
   logic [7:0]  fragment_index;
   logic [6:0]  ack_mask;
   logic        field_end;
   logic        is_last_fragment;
   logic [13:0] fragment_size;
   logic [7:0]  payload_byte;
   logic        fragment_done;
   logic [2:0]  fail_code;
   logic        datagram_done;

   modport source (
      output valid, output kind, output message_id, output fragment_index,
      output ack_mask, output field_end, output is_last_fragment,
      output fragment_size, output payload_byte, output fragment_done,
      output fail_code, output datagram_done, input ready
   );
   modport sink (
      input valid, input kind, input message_id, input fragment_index,
      input ack_mask, input field_end, input is_last_fragment,
      input fragment_size, input payload_byte, input fragment_done,
      input fail_code, input datagram_done, output ready
   );
endinterface

// ===== hdl/sdmd_in_stage.sv =====
module sdmd_in_stage (
   input  logic               clock,
   input  logic               reset,
   sdmd_req_if.sink           req_chan,
   input  logic               take,
   output logic               item_valid,
   output sdmd_pkg::item_type item
);

   logic               valid_ff;
   logic               valid_in;
   sdmd_pkg::item_type item_ff;
   logic               load;

   // A new word may enter whenever the register is empty or is being drained.
   assign req_chan.ready = !valid_ff || take;
   assign load           = req_chan.valid && req_chan.ready;
   assign valid_in       = load ? 1'b1 : (take ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff.data_byte       <= req_chan.data_byte;
         item_ff.end_of_datagram <= req_chan.end_of_datagram;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== hdl/sdmd_parser.sv =====
module sdmd_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_valid,
   input  sdmd_pkg::item_type   item,
   input  logic                 out_ready,
   output logic                 take,
   output logic                 res_valid,
   output sdmd_pkg::result_type res
);

   sdmd_pkg::phase_type phase_ff, phase_in;
   logic [1:0]  flag_bits_ff, flag_bits_in;
   logic [7:0]  items_left_ff, items_left_in;
   logic [2:0]  byte_pos_ff, byte_pos_in;
   logic [31:0] id_shift_ff, id_shift_in;
   logic [23:0] info_shift_ff, info_shift_in;
   logic [13:0] data_left_ff, data_left_in;
   logic [4:0]  bf_count_ff, bf_count_in;

   logic                 have;
   logic [2:0]           err;
   logic [7:0]           b;
   logic [7:0]           items_dec;
   logic [13:0]          data_dec;
   logic [31:0]          id_next;
   logic [23:0]          info_next;
   sdmd_pkg::phase_type  after_acks;
   sdmd_pkg::phase_type  after_frag;
   sdmd_pkg::result_type r;

   assign take      = item_valid && out_ready;
   assign res_valid = item_valid && have;
   assign res       = r;

   assign b          = item.data_byte;
   assign items_dec  = items_left_ff - 8'd1;
   assign data_dec   = data_left_ff - 14'd1;
   assign id_next    = {id_shift_ff[23:0], b};
   assign info_next  = {info_shift_ff[15:0], b};
   assign after_acks = flag_bits_ff[0] ? sdmd_pkg::PH_BF_COUNT : sdmd_pkg::PH_FRAG_COUNT;
   assign after_frag = (items_dec != 8'd0) ? sdmd_pkg::PH_FRAG_HDR : sdmd_pkg::PH_TAIL;

   always_comb begin
      phase_in      = phase_ff;
      flag_bits_in  = flag_bits_ff;
      items_left_in = items_left_ff;
      byte_pos_in   = byte_pos_ff;
      id_shift_in   = id_shift_ff;
      info_shift_in = info_shift_ff;
      data_left_in  = data_left_ff;
      bf_count_in   = bf_count_ff;
      have          = 1'b0;
      err           = sdmd_pkg::ERR_NONE;
      r             = '0;

      unique case (phase_ff)
         sdmd_pkg::PH_FLAG: begin
            flag_bits_in = {b[7], b[6]};
            if (b[7]) begin
               phase_in = sdmd_pkg::PH_ACK_COUNT;
            end else if (b[6]) begin
               phase_in = sdmd_pkg::PH_BF_COUNT;
            end else begin
               phase_in = sdmd_pkg::PH_FRAG_COUNT;
            end
         end
         sdmd_pkg::PH_ACK_COUNT: begin
            items_left_in = b;
            byte_pos_in   = 3'd0;
            phase_in      = (b != 8'd0) ? sdmd_pkg::PH_ACK_ID : after_acks;
         end
         sdmd_pkg::PH_ACK_ID: begin
            id_shift_in = id_next;
            byte_pos_in = byte_pos_ff + 3'd1;
            if (byte_pos_ff == sdmd_pkg::POS_ID_LAST) begin
               byte_pos_in   = 3'd0;
               have          = 1'b1;
               r.kind        = sdmd_pkg::KIND_ACK_ID;
               r.message_id  = id_next;
               items_left_in = items_dec;
               if (items_dec == 8'd0) begin
                  phase_in = after_acks;
               end
            end
         end
         sdmd_pkg::PH_BF_COUNT: begin
            items_left_in = b;
            byte_pos_in   = 3'd0;
            phase_in      = (b != 8'd0) ? sdmd_pkg::PH_BF_ID : sdmd_pkg::PH_FRAG_COUNT;
         end
         sdmd_pkg::PH_BF_ID: begin
            id_shift_in = id_next;
            byte_pos_in = byte_pos_ff + 3'd1;
            if (byte_pos_ff == sdmd_pkg::POS_ID_LAST) begin
               byte_pos_in = 3'd0;
               bf_count_in = 5'd0;
               phase_in    = sdmd_pkg::PH_BF_BYTE;
            end
         end
         sdmd_pkg::PH_BF_BYTE: begin
            have             = 1'b1;
            r.kind           = sdmd_pkg::KIND_ACK_BITS;
            r.message_id     = id_shift_ff;
            // Base index is the byte count times seven.
            r.fragment_index = {bf_count_ff, 3'b000} - {3'b000, bf_count_ff};
            // Byte bit 6 is the first fragment of this byte, so reverse bits 6..0.
            r.ack_mask       = {b[0], b[1], b[2], b[3], b[4], b[5], b[6]};
            r.field_end      = !b[7];
            if (bf_count_ff < sdmd_pkg::BF_COUNT_MAX) begin
               bf_count_in = bf_count_ff + 5'd1;
            end
            if (!b[7]) begin
               bf_count_in   = 5'd0;
               items_left_in = items_dec;
               phase_in      = (items_dec != 8'd0) ? sdmd_pkg::PH_BF_ID
                                                   : sdmd_pkg::PH_FRAG_COUNT;
            end
         end
         sdmd_pkg::PH_FRAG_COUNT: begin
            items_left_in = b;
            byte_pos_in   = 3'd0;
            phase_in      = (b != 8'd0) ? sdmd_pkg::PH_FRAG_HDR : sdmd_pkg::PH_TAIL;
         end
         sdmd_pkg::PH_FRAG_HDR: begin
            if (byte_pos_ff < 3'd4) begin
               id_shift_in = id_next;
            end else begin
               info_shift_in = info_next;
            end
            byte_pos_in = byte_pos_ff + 3'd1;
            if (byte_pos_ff == sdmd_pkg::POS_HDR_LAST) begin
               byte_pos_in        = 3'd0;
               have               = 1'b1;
               r.kind             = sdmd_pkg::KIND_FRAG_HDR;
               r.message_id       = id_shift_ff;
               r.fragment_index   = {1'b0, info_next[23:17]};
               r.is_last_fragment = info_next[16];
               r.fragment_size    = info_next[13:0];
               data_left_in       = info_next[13:0];
               if (info_next[13:0] != 14'd0) begin
                  phase_in = sdmd_pkg::PH_FRAG_DATA;
               end else begin
                  items_left_in = items_dec;
                  phase_in      = after_frag;
               end
            end
         end
         sdmd_pkg::PH_FRAG_DATA: begin
            data_left_in     = data_dec;
            have             = 1'b1;
            r.kind           = sdmd_pkg::KIND_FRAG_DATA;
            r.message_id     = id_shift_ff;
            r.fragment_index = {1'b0, info_shift_ff[23:17]};
            r.payload_byte   = b;
            r.fragment_done  = (data_dec == 14'd0);
            if (data_dec == 14'd0) begin
               items_left_in = items_dec;
               byte_pos_in   = 3'd0;
               phase_in      = after_frag;
            end
         end
         sdmd_pkg::PH_TAIL: begin
            // Trailing bytes after the last fragment are dropped.
         end
         default: begin
            phase_in = sdmd_pkg::PH_FLAG;
         end
      endcase

      if (item.end_of_datagram) begin
         unique case (phase_in)
            sdmd_pkg::PH_ACK_COUNT, sdmd_pkg::PH_ACK_ID: err = sdmd_pkg::ERR_ACKS_CUT;
            sdmd_pkg::PH_BF_COUNT, sdmd_pkg::PH_BF_ID,
            sdmd_pkg::PH_BF_BYTE:                        err = sdmd_pkg::ERR_BITS_CUT;
            sdmd_pkg::PH_FLAG, sdmd_pkg::PH_FRAG_COUNT:  err = sdmd_pkg::ERR_NO_COUNT;
            sdmd_pkg::PH_FRAG_HDR:                       err = sdmd_pkg::ERR_HDR_CUT;
            sdmd_pkg::PH_FRAG_DATA:                      err = sdmd_pkg::ERR_DATA_CUT;
            default:                                     err = sdmd_pkg::ERR_NONE;
         endcase
         if (err != sdmd_pkg::ERR_NONE) begin
            r           = '0;
            r.kind      = sdmd_pkg::KIND_ERROR;
            r.fail_code = err;
         end else if (!have) begin
            r.kind = sdmd_pkg::KIND_DGRAM_OK;
         end
         r.datagram_done = 1'b1;
         have            = 1'b1;
         phase_in        = sdmd_pkg::PH_FLAG;
         flag_bits_in    = 2'd0;
         items_left_in   = 8'd0;
         byte_pos_in     = 3'd0;
         id_shift_in     = 32'd0;
         info_shift_in   = 24'd0;
         data_left_in    = 14'd0;
         bf_count_in     = 5'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= sdmd_pkg::PH_FLAG;
         flag_bits_ff  <= 2'd0;
         items_left_ff <= 8'd0;
         byte_pos_ff   <= 3'd0;
         id_shift_ff   <= 32'd0;
         info_shift_ff <= 24'd0;
         data_left_ff  <= 14'd0;
         bf_count_ff   <= 5'd0;
      end else if (take) begin
         phase_ff      <= phase_in;
         flag_bits_ff  <= flag_bits_in;
         items_left_ff <= items_left_in;
         byte_pos_ff   <= byte_pos_in;
         id_shift_ff   <= id_shift_in;
         info_shift_ff <= info_shift_in;
         data_left_ff  <= data_left_in;
         bf_count_ff   <= bf_count_in;
      end
   end

   // The end of a datagram always produces a result and rewinds the parser.
   a_eod_result: assert property (@(posedge clock) disable iff (reset)
      item_valid && item.end_of_datagram |-> have && r.datagram_done)
      else $error("end of datagram produced no result");

   a_eod_rewind: assert property (@(posedge clock) disable iff (reset)
      take && item.end_of_datagram |=> phase_ff == sdmd_pkg::PH_FLAG)
      else $error("parser did not rewind after end of datagram");

   a_data_result: assert property (@(posedge clock) disable iff (reset)
      item_valid && phase_ff == sdmd_pkg::PH_FRAG_DATA |->
         have && (r.kind == sdmd_pkg::KIND_FRAG_DATA || r.kind == sdmd_pkg::KIND_ERROR))
      else $error("fragment data word gave no data result");

   a_bf_index: assert property (@(posedge clock) disable iff (reset)
      res_valid && r.kind == sdmd_pkg::KIND_ACK_BITS |-> r.fragment_index <= sdmd_pkg::BF_INDEX_MAX)
      else $error("bitfield base index out of range");

endmodule

// ===== hdl/sdmd_out_stage.sv =====
module sdmd_out_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 res_valid,
   input  sdmd_pkg::result_type res,
   output logic                 out_ready,
   sdmd_rsp_if.source           rsp_chan
);

   logic                 valid_ff;
   logic                 valid_in;
   sdmd_pkg::result_type res_ff;
   logic                 load;

   // The register refills in the same cycle that its word is taken.
   assign out_ready = !valid_ff || rsp_chan.ready;
   assign load      = res_valid && out_ready;
   assign valid_in  = load ? 1'b1 : (rsp_chan.ready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= res;
      end
   end

   assign rsp_chan.valid            = valid_ff;
   assign rsp_chan.kind             = res_ff.kind;
   assign rsp_chan.message_id       = res_ff.message_id;
   assign rsp_chan.fragment_index   = res_ff.fragment_index;
   assign rsp_chan.ack_mask         = res_ff.ack_mask;
   assign rsp_chan.field_end        = res_ff.field_end;
   assign rsp_chan.is_last_fragment = res_ff.is_last_fragment;
   assign rsp_chan.fragment_size    = res_ff.fragment_size;
   assign rsp_chan.payload_byte     = res_ff.payload_byte;
   assign rsp_chan.fragment_done    = res_ff.fragment_done;
   assign rsp_chan.fail_code        = res_ff.fail_code;
   assign rsp_chan.datagram_done    = res_ff.datagram_done;

endmodule

// ===== hdl/ssu_data_message_deframer_unit.sv =====
// Path: an accepted byte is held in the input register, parsed combinationally, and
// its result word is loaded into the output register.
// Throughput: one datagram byte per cycle; each byte gives at most one result word,
// and the input stalls only while the sink holds off a waiting result word.
// Reset (synchronous, active high) empties both registers and returns the parser
// to the state that expects a flag byte, with all counters and shifters cleared.
module ssu_data_message_deframer_unit (
   input  logic       clock,
   input  logic       reset,
   sdmd_req_if.sink   req_chan,
   sdmd_rsp_if.source rsp_chan
);

   // The input register holds one datagram byte until the parser consumes it.
   // The parser consumes a byte only when the output register can take its
   // result, so a stalled result never loses parser state.
   logic                 item_valid;
   sdmd_pkg::item_type   item;
   logic                 take;
   logic                 res_valid;
   sdmd_pkg::result_type res;
   logic                 out_ready;

   sdmd_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   // All parsing for one byte is done here in a single pass: phase decode,
   // shift of the id or info word, counter updates, and result assembly.
   // The end-of-datagram mark turns the result into an error word on a cut field, or a
   // datagram-ok word if the byte gave none, marks it done and rewinds the parser.
   sdmd_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .out_ready  (out_ready),
      .take       (take),
      .res_valid  (res_valid),
      .res        (res)
   );

   // The output register presents the result word until the sink takes it.
   sdmd_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res       (res),
      .out_ready (out_ready),
      .rsp_chan  (rsp_chan)
   );

endmodule
